/* hdl/sppi_pkg.sv */
// Shared types and constants for the spectral peak interpolation unit.
`timescale 1ns / 1ps
package sppi_pkg;

  localparam int BW_W     = 32;   // bin width register, Q16.16
  localparam int FRAC_W   = 16;
  localparam int FREQ_W   = 40;   // Q24.16 frequency
  localparam int POW_W    = 26;
  localparam int COUNT_W  = 12;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD  = OUT_DATA_W - (FREQ_W + POW_W + COUNT_W);

  localparam logic [BW_W-1:0]    BW_RESET   = 32'h0001_0000;
  localparam logic [FRAC_W-1:0]  ROUND_HALF = 16'h8000;
  localparam logic [POW_W-1:0]   POW_MAX    = {POW_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

  // register index (byte address bit 2)
  localparam logic REG_BIN_WIDTH = 1'b0;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [POW_W-1:0]  power;
    logic              flat;
  } sppi_res_t;

endpackage

/* hdl/sppi_mdu.sv */
// Shared radix-2 multiply / divide unit: one add or trial subtract per cycle.
`timescale 1ns / 1ps
module sppi_mdu #(
  parameter int W = 76
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sppi_pkg::mdu_cmd_t       cmd,
  input  logic [$clog2(W+1)-1:0]   steps,
  input  logic [W-1:0]             acc_init,
  input  logic [W-1:0]             opnd_init,
  input  logic [W-1:0]             sh_init,
  output logic                     done,
  output logic [W-1:0]             acc,
  output logic [W-1:0]             sh
);
  import sppi_pkg::*;

  localparam int CW = $clog2(W+1);

  logic [W-1:0]  opnd;
  logic [CW-1:0] cnt;
  mdu_op_t       op;

  logic [W-1:0] rem_sh;
  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic         add_ci;
  logic [W:0]   add_s;

  // mul: acc + opnd; div: (rem << 1 | next numerator bit) - divisor
  always_comb begin
    rem_sh = {acc[W-2:0], sh[W-1]};
    if (op == OP_DIV) begin
      add_a  = rem_sh;
      add_b  = ~opnd;
      add_ci = 1'b1;
    end else begin
      add_a  = acc;
      add_b  = opnd;
      add_ci = 1'b0;
    end
    add_s = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_ci};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt  <= steps;
        op   <= cmd.op;
        acc  <= acc_init;
        opnd <= opnd_init;
        sh   <= sh_init;
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
        case (op)
          OP_DIV: begin
            // carry out set: no borrow, quotient bit is one
            acc <= add_s[W] ? add_s[W-1:0] : rem_sh;
            sh  <= {sh[W-2:0], add_s[W]};
          end
          OP_MUL: begin
            if (sh[0]) begin
              acc <= add_s[W-1:0];
            end
            opnd <= {opnd[W-2:0], 1'b0};
            sh   <= {1'b0, sh[W-1:1]};
          end
          default: begin
            acc <= acc;
          end
        endcase
      end
    end
  end

endmodule

/* hdl/sppi_core.sv */
// Sequencer for one parabolic fit: drives the shared unit, rounds and saturates.
`timescale 1ns / 1ps
module sppi_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int M_W         = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SAMPLE_BITS-1:0]    pm,
  input  logic [SAMPLE_BITS-1:0]    p0,
  input  logic [SAMPLE_BITS-1:0]    pp,
  input  logic [M_W-1:0]            m,
  input  logic [sppi_pkg::BW_W-1:0] bin_width,
  input  logic                      take,
  output logic                      res_valid,
  output sppi_pkg::sppi_res_t       res
);
  import sppi_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int AMAG_W = S + 1;
  localparam int A2_W   = S + 3;
  localparam int N1W    = S + 18;           // (|b| << 17) + 2|a|
  localparam int MS_W   = M_W + FRAC_W;     // m in Q.16
  localparam int PMAX_W = (MS_W > N1W) ? MS_W : N1W;
  localparam int PSW    = PMAX_W + 2;       // signed position
  localparam int POS_W  = PSW - 1;
  localparam int W      = POS_W + BW_W;
  localparam int CW     = $clog2(W+1);
  localparam int SQ_W   = 2 * S;
  localparam int R_W    = S + 4;            // remainder below 8|a|
  localparam int V_W    = (SQ_W + 2 > POW_W + 1) ? SQ_W + 2 : POW_W + 1;
  localparam int SAT_LO = FREQ_W + FRAC_W;

  typedef enum logic [3:0] {
    C_IDLE,
    C_PREP,
    C_DIV1,
    C_POS,
    C_MULF,
    C_BSQ,
    C_DIV2,
    C_PWR,
    C_DONE
  } state_t;

  state_t state;

  logic [S-1:0]      s_pm, s_p0, s_pp;
  logic [M_W-1:0]    s_m;
  logic [AMAG_W-1:0] amag;
  logic [S-1:0]      bmag;
  logic              a_neg, off_neg, flat;
  logic [N1W-1:0]    q1;
  logic [POS_W-1:0]  posmag;
  logic [SQ_W-1:0]   bsq;
  logic [SQ_W-1:0]   q2;
  logic [R_W-1:0]    rem;
  logic              go;

  // unit connections
  mdu_cmd_t        cmd;
  logic [CW-1:0]   steps;
  logic [W-1:0]    acc_init, opnd_init, sh_init;
  logic            mdu_done;
  logic [W-1:0]    mdu_acc, mdu_sh;

  // combinational helpers
  logic signed [A2_W-1:0] a2, b2, a2_abs, b2_abs;
  logic [N1W-1:0]         num1;
  logic [MS_W-1:0]        ms;
  logic signed [PSW-1:0]  ms_ext, q1_ext, pos;
  logic [FREQ_W-1:0]      freq_sat;
  logic                   rnd;
  logic [SQ_W:0]          q2r;
  logic [V_W-1:0]         pe, qe, pwr_v;
  logic [POW_W-1:0]       pow_sat;

  always_comb begin
    a2 = $signed({3'b000, s_pp}) + $signed({3'b000, s_pm}) - $signed({2'b00, s_p0, 1'b0});
    b2 = $signed({3'b000, s_pp}) - $signed({3'b000, s_pm});
    a2_abs = a2[A2_W-1] ? -a2 : a2;
    b2_abs = b2[A2_W-1] ? -b2 : b2;
    num1 = {1'b0, bmag, 17'b0} + {{(N1W-AMAG_W-1){1'b0}}, amag, 1'b0};
    ms = {s_m, {FRAC_W{1'b0}}};
    ms_ext = $signed({{(PSW-MS_W){1'b0}}, ms});
    q1_ext = $signed({{(PSW-N1W){1'b0}}, q1});
    pos = off_neg ? (ms_ext - q1_ext) : (ms_ext + q1_ext);

    // product is Q.32 with the half already added; saturate at 2^56 and above
    freq_sat = (|mdu_acc[W-1:SAT_LO]) ? {FREQ_W{1'b1}} : mdu_acc[SAT_LO-1:FRAC_W];

    rnd = ({rem, 1'b0} >= {1'b0, amag, 3'b000});
    q2r = {1'b0, q2} + {{SQ_W{1'b0}}, rnd};
    pe  = {{(V_W-S){1'b0}}, s_p0};
    qe  = {{(V_W-SQ_W-1){1'b0}}, q2r};
    if (flat) begin
      pwr_v = pe;
    end else if (a_neg) begin
      pwr_v = pe + qe;
    end else if (qe >= pe) begin
      pwr_v = '0;
    end else begin
      pwr_v = pe - qe;
    end
    pow_sat = (pwr_v > {{(V_W-POW_W){1'b0}}, POW_MAX}) ? POW_MAX : pwr_v[POW_W-1:0];
  end

  // operand selection for the shared unit
  always_comb begin
    cmd.start = go;
    cmd.op    = OP_MUL;
    steps     = '0;
    acc_init  = '0;
    opnd_init = '0;
    sh_init   = '0;
    case (state)
      C_DIV1: begin
        cmd.op    = OP_DIV;
        steps     = CW'(N1W);
        opnd_init = {{(W-AMAG_W-2){1'b0}}, amag, 2'b00};
        sh_init   = {num1, {(W-N1W){1'b0}}};
      end
      C_MULF: begin
        steps     = CW'(BW_W);
        acc_init  = {{(W-FRAC_W){1'b0}}, ROUND_HALF};
        opnd_init = {{(W-POS_W){1'b0}}, posmag};
        sh_init   = {{(W-BW_W){1'b0}}, bin_width};
      end
      C_BSQ: begin
        steps     = CW'(S);
        opnd_init = {{(W-S){1'b0}}, bmag};
        sh_init   = {{(W-S){1'b0}}, bmag};
      end
      C_DIV2: begin
        cmd.op    = OP_DIV;
        steps     = CW'(SQ_W);
        opnd_init = {{(W-AMAG_W-3){1'b0}}, amag, 3'b000};
        sh_init   = {bsq, {(W-SQ_W){1'b0}}};
      end
      default: begin
        steps = '0;
      end
    endcase
  end

  sppi_mdu #(
    .W (W)
  ) u_mdu (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .steps     (steps),
    .acc_init  (acc_init),
    .opnd_init (opnd_init),
    .sh_init   (sh_init),
    .done      (mdu_done),
    .acc       (mdu_acc),
    .sh        (mdu_sh)
  );

  assign res_valid = (state == C_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            s_pm  <= pm;
            s_p0  <= p0;
            s_pp  <= pp;
            s_m   <= m;
            state <= C_PREP;
          end
        end
        C_PREP: begin
          amag    <= a2_abs[AMAG_W-1:0];
          bmag    <= b2_abs[S-1:0];
          a_neg   <= a2[A2_W-1];
          off_neg <= (a2 > 0 && b2 > 0) || (a2 < 0 && b2 < 0);
          flat    <= (a2 == '0);
          posmag  <= {{(POS_W-MS_W){1'b0}}, ms};
          go      <= 1'b1;
          state   <= (a2 == '0) ? C_MULF : C_DIV1;
        end
        C_DIV1: begin
          if (mdu_done) begin
            q1    <= mdu_sh[N1W-1:0];
            state <= C_POS;
          end
        end
        C_POS: begin
          // a position at or below zero gives frequency zero
          posmag <= pos[PSW-1] ? '0 : pos[POS_W-1:0];
          go     <= 1'b1;
          state  <= C_MULF;
        end
        C_MULF: begin
          if (mdu_done) begin
            res.freq <= freq_sat;
            res.flat <= flat;
            if (flat) begin
              res.power <= pow_sat;
              state     <= C_DONE;
            end else begin
              go    <= 1'b1;
              state <= C_BSQ;
            end
          end
        end
        C_BSQ: begin
          if (mdu_done) begin
            bsq   <= mdu_acc[SQ_W-1:0];
            go    <= 1'b1;
            state <= C_DIV2;
          end
        end
        C_DIV2: begin
          if (mdu_done) begin
            q2    <= mdu_sh[SQ_W-1:0];
            rem   <= mdu_acc[R_W-1:0];
            state <= C_PWR;
          end
        end
        C_PWR: begin
          res.power <= pow_sat;
          state     <= C_DONE;
        end
        C_DONE: begin
          if (take) begin
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/spectral_peak_parabolic_interp_unit.sv */
// Top level: bin window, frame counters, stream and register ports, result register.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+-----------------------------------
//   s_*       | in        | s_tvalid / s_tready    | tdata power, tuser peak_flag,
//             |           |                        | tlast last_bin
//   m_*       | out       | m_tvalid / m_tready    | tdata freq, power, count;
//             |           |                        | tuser peak_valid, flat_peak;
//             |           |                        | tlast frame_done
//   apb       | in/out    | psel/penable/pready    | bin_width at byte address 0
//
// A bin that completes no peak leaves s_tready high. A bin that completes a
// peak starts the fit: s_tready stays low until the result is taken, while
// the bit-per-cycle divisions and multiplies run on the one shared unit; a
// flat peak skips the divisions and the squaring. s_tready is also low while a
// result beat waits on a stalled output. Reset is synchronous, active
// high, and clears counters, window and bin_width to 1.0 Hz.
`timescale 1ns / 1ps
module spectral_peak_parabolic_interp_unit #(
  parameter int MAX_BINS    = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // bin stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] power
  input  logic [0:0]                             s_tuser,   // [0] peak_flag
  input  logic                                   s_tlast,   // last_bin
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [sppi_pkg::OUT_DATA_W-1:0]        m_tdata,   // [39:0] peak_freq,
                                                            // [65:40] peak_power,
                                                            // [77:66] peak_count
  output logic [1:0]                             m_tuser,   // [0] peak_valid, [1] flat_peak
  output logic                                   m_tlast,   // frame_done
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import sppi_pkg::*;

  localparam int CNT_W = $clog2(MAX_BINS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS - 1);

  logic [BW_W-1:0]        bin_width;
  logic [SAMPLE_BITS-1:0] older, centre;
  logic                   centre_flag;
  logic [CNT_W-1:0]       bin_cnt;
  logic [COUNT_W-1:0]     peaks_found;

  // pending fit
  logic               job_active;
  logic               pend_last;
  logic [COUNT_W-1:0] pend_count;

  // result register
  logic               out_pv, out_flat, out_last;
  logic [FREQ_W-1:0]  out_freq;
  logic [POW_W-1:0]   out_power;
  logic [COUNT_W-1:0] out_count;

  logic                   accept, cfg_wr, out_free;
  logic [SAMPLE_BITS-1:0] x;
  logic                   at_sat, has_peak;
  logic [COUNT_W-1:0]     cnt_inc;
  logic                   core_start, core_take, core_valid;
  sppi_res_t              core_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BIN_WIDTH);
  assign prdata = (paddr[2] == REG_BIN_WIDTH) ? bin_width : '0;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !job_active && out_free;
  assign accept   = s_tvalid && s_tready;
  assign x        = s_tdata[SAMPLE_BITS-1:0];

  // saturated counter: this bin's flag is dropped, no index advance
  assign at_sat   = (bin_cnt == CNT_MAX);
  // centre bin is interior once the incoming bin index reaches two
  assign has_peak = centre_flag && (bin_cnt >= CNT_W'(2));
  assign cnt_inc  = (peaks_found == COUNT_MAX) ? peaks_found : peaks_found + COUNT_W'(1);

  assign core_start = accept && has_peak;
  assign core_take  = job_active && core_valid && out_free;

  sppi_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .M_W         (CNT_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (core_start),
    .pm        (older),
    .p0        (centre),
    .pp        (x),
    .m         (bin_cnt - CNT_W'(1)),
    .bin_width (bin_width),
    .take      (core_take),
    .res_valid (core_valid),
    .res       (core_res)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, out_count, out_power, out_freq};
  assign m_tuser = {out_flat, out_pv};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width   <= BW_RESET;
      older       <= '0;
      centre      <= '0;
      centre_flag <= 1'b0;
      bin_cnt     <= '0;
      peaks_found <= '0;
      job_active  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        bin_width <= pwdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        older       <= centre;
        centre      <= x;
        centre_flag <= at_sat ? 1'b0 : s_tuser[0];
        if (!at_sat) begin
          bin_cnt <= bin_cnt + CNT_W'(1);
        end
        if (has_peak) begin
          peaks_found <= cnt_inc;
          job_active  <= 1'b1;
          pend_last   <= s_tlast;
          pend_count  <= cnt_inc;
        end else if (s_tlast) begin
          // end of frame with no peak: frame-done beat right away
          m_tvalid  <= 1'b1;
          out_pv    <= 1'b0;
          out_freq  <= '0;
          out_power <= '0;
          out_flat  <= 1'b0;
          out_last  <= 1'b1;
          out_count <= peaks_found;
        end
        if (s_tlast) begin
          bin_cnt     <= '0;
          peaks_found <= '0;
          centre_flag <= 1'b0;
        end
      end
      if (core_take) begin
        m_tvalid   <= 1'b1;
        out_pv     <= 1'b1;
        out_freq   <= core_res.freq;
        out_power  <= core_res.power;
        out_flat   <= core_res.flat;
        out_last   <= pend_last;
        out_count  <= pend_count;
        job_active <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb_spectral_peak_parabolic_interp_unit.sv */
// Self-checking testbench for the spectral peak parabolic interpolation unit.
`timescale 1ns / 1ps
module tb_spectral_peak_parabolic_interp_unit;
  import sppi_pkg::*;

  localparam int MAX_BINS    = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int S_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  // settle time covers the longest fit, with room on top
  localparam int SETTLE_CYCLES = 250;
  localparam longint unsigned HZ_SAT  = (64'd1 << FREQ_W) - 1;
  localparam longint unsigned PWR_SAT = (64'd1 << POW_W) - 1;

  // one result beat as the block reports it
  typedef struct packed {
    logic               valid;
    logic [FREQ_W-1:0]  freq;
    logic [POW_W-1:0]   power;
    logic               flat;
    logic               done;
    logic [COUNT_W-1:0] count;
  } peak_report_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;  // [23:0] power
  logic [0:0]          s_tuser  = '0;  // [0] peak_flag
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;      // [39:0] freq, [65:40] power, [77:66] count
  logic [1:0]          m_tuser;        // [0] peak_valid, [1] flat_peak
  logic                m_tlast;        // frame_done
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  spectral_peak_parabolic_interp_unit #(
    .MAX_BINS   (MAX_BINS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // predictor copy of the block state
  longint unsigned bw_reg    = 64'(BW_RESET);
  longint unsigned win_prev  = 0;
  longint unsigned win_mid   = 0;
  logic            mid_flag  = 1'b0;
  int              bin_idx   = 0;
  int              peak_tally = 0;

  peak_report_t peak_reports[$];
  int  mismatches = 0;
  bit  gaps_on    = 1'b1;

  // Q.16 position times Q16.16 bin width, rounded half up to Q24.16
  function automatic longint unsigned scale_to_hz(longint unsigned pos_q16);
    longint unsigned lim, prod, f;
    lim = (64'd1 << 56) - 1;
    if (bw_reg == 0 || pos_q16 == 0) return 0;
    if (pos_q16 > lim / bw_reg) return HZ_SAT;
    prod = pos_q16 * bw_reg;
    f = (prod + 64'h8000) >> 16;
    return (f > HZ_SAT) ? HZ_SAT : f;
  endfunction

  // three-point fit around centre bin m
  task automatic parabola_fit(input longint unsigned pm, input longint unsigned p0,
                              input longint unsigned pp, input longint unsigned m,
                              output longint unsigned freq, output longint unsigned pwr,
                              output logic flat);
    longint a2, b2, pos;
    longint unsigned amag, bmag, den, q, r, b2sq, s;
    bit neg;
    a2 = longint'(pp) + longint'(pm) - 2 * longint'(p0);
    b2 = longint'(pp) - longint'(pm);
    if (a2 == 0) begin
      // flat top: centre bin values
      flat = 1'b1;
      freq = scale_to_hz(m << 16);
      pwr  = (p0 > PWR_SAT) ? PWR_SAT : p0;
    end else begin
      flat = 1'b0;
      amag = (a2 < 0) ? longint'(-a2) : longint'(a2);
      bmag = (b2 < 0) ? longint'(-b2) : longint'(b2);
      // offset -b/2a in Q.16, half away from zero
      den = 2 * amag;
      q = (2 * (bmag << 16) + den) / (2 * den);
      neg = (b2 > 0 && a2 > 0) || (b2 < 0 && a2 < 0);
      pos = longint'(m << 16);
      if (neg) pos = pos - longint'(q);
      else     pos = pos + longint'(q);
      freq = (pos <= 0) ? 0 : scale_to_hz(longint'(pos));
      // power correction b^2/4a, half up in magnitude
      b2sq = bmag * bmag;
      den = 8 * amag;
      q = b2sq / den;
      r = b2sq % den;
      if (r >= den - r) q++;
      if (a2 < 0) begin
        s = p0 + q;
        pwr = (s > PWR_SAT) ? PWR_SAT : s;
      end else begin
        pwr = (q >= p0) ? 0 : (((p0 - q) > PWR_SAT) ? PWR_SAT : p0 - q);
      end
    end
  endtask

  // advance the window by one accepted bin, queue the beat it causes
  task automatic fit_bin(input logic [SAMPLE_BITS-1:0] pw, input logic flag, input logic last);
    int n;
    bit sat;
    longint unsigned freq, pwr;
    logic flat, valid;
    peak_report_t rep;
    n = bin_idx;
    sat = (n >= MAX_BINS - 1);
    valid = 1'b0;
    freq = 0;
    pwr = 0;
    flat = 1'b0;
    if (mid_flag && n >= 2) begin
      parabola_fit(win_prev, win_mid, 64'(pw), 64'(n - 1), freq, pwr, flat);
      valid = 1'b1;
      if (peak_tally < COUNT_MAX) peak_tally++;
    end
    win_prev = win_mid;
    win_mid  = 64'(pw);
    mid_flag = sat ? 1'b0 : flag;
    if (!sat) bin_idx = n + 1;
    if (valid || last) begin
      rep.valid = valid;
      rep.freq  = freq[FREQ_W-1:0];
      rep.power = pwr[POW_W-1:0];
      rep.flat  = flat;
      rep.done  = last;
      rep.count = peak_tally[COUNT_W-1:0];
      peak_reports.push_back(rep);
    end
    if (last) begin
      bin_idx = 0;
      peak_tally = 0;
      mid_flag = 1'b0;
    end
  endtask

  task automatic log_miss(input string what, input peak_report_t want, input peak_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want v=%0b f=%h p=%h fl=%0b d=%0b c=%0d | got v=%0b f=%h p=%h fl=%0b d=%0b c=%0d",
               $realtime, what, want.valid, want.freq, want.power, want.flat, want.done,
               want.count, got.valid, got.freq, got.power, got.flat, got.done, got.count);
  endtask

  // result side: random stall bursts between stretches of ready
  initial begin
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (gaps_on) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    peak_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.valid = m_tuser[0];
      got.flat  = m_tuser[1];
      got.done  = m_tlast;
      got.freq  = m_tdata[FREQ_W-1:0];
      got.power = m_tdata[FREQ_W +: POW_W];
      got.count = m_tdata[FREQ_W+POW_W +: COUNT_W];
      if (peak_reports.size() == 0) begin
        want = '0;
        log_miss("beat with nothing expected", want, got);
      end else begin
        want = peak_reports.pop_front();
        if (got.valid !== want.valid || got.freq !== want.freq ||
            got.power !== want.power || got.flat !== want.flat ||
            got.done !== want.done || got.count !== want.count)
          log_miss("result mismatch", want, got);
      end
    end
  end

  // one bin beat; valid stays high into the next call unless a gap is drawn
  task automatic push_bin(input logic [SAMPLE_BITS-1:0] pw, input logic flag, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pw;
    s_tuser  <= flag;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fit_bin(pw, flag, last);
  endtask

  // stop input, wait for every pending beat, then let the block settle
  task automatic drain;
    s_tvalid <= 1'b0;
    while (peak_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_BIN_WIDTH, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write while idle, with read-back
  task automatic set_bin_width(input logic [31:0] bw);
    logic [31:0] rd;
    peak_report_t want, got;
    drain();
    apb_xfer(1'b1, bw, rd);
    bw_reg = 64'(bw);
    apb_xfer(1'b0, '0, rd);
    if (rd !== bw) begin
      want = '0;
      got  = '0;
      want.freq = FREQ_W'(bw);
      got.freq  = FREQ_W'(rd);
      log_miss("bin_width read-back", want, got);
    end
  endtask

  function automatic logic [SAMPLE_BITS-1:0] bin_power(input int style,
                                                        input logic [SAMPLE_BITS-1:0] base);
    case (style)
      0: return SAMPLE_BITS'($urandom);
      1: return SAMPLE_BITS'($urandom_range(0, 3));           // flat tops are common here
      2: return base + SAMPLE_BITS'($urandom_range(0, 15));   // gentle curvature near a level
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return SAMPLE_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_random_frame(input int len);
    int flag_pct, style, i;
    logic [SAMPLE_BITS-1:0] base;
    case ($urandom_range(0, 3))
      0: flag_pct = 0;
      1: flag_pct = 25;
      2: flag_pct = 50;
      default: flag_pct = 100;
    endcase
    style = $urandom_range(0, 3);
    base  = SAMPLE_BITS'($urandom);
    for (i = 0; i < len; i++)
      push_bin(bin_power(style, base), ($urandom_range(0, 99) < flag_pct), (i == len - 1));
  endtask

  function automatic int frame_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
  endfunction

  // one- and two-bin frames: end of frame only, flags have no interior bin
  task automatic test_short_frames;
    push_bin(24'd5, 1'b1, 1'b1);
    push_bin(24'd0, 1'b1, 1'b0);
    push_bin(24'd7, 1'b1, 1'b1);
  endtask

  // concave peak, flat top, upward bend with power clamped to zero, power overflow
  task automatic test_peak_shapes;
    push_bin(24'd0,        1'b0, 1'b0);
    push_bin(24'hFFFFFF,   1'b1, 1'b0);
    push_bin(24'd0,        1'b0, 1'b0);
    push_bin(24'd5,        1'b0, 1'b1);
    // flat top, reported together with end of frame
    push_bin(24'd10,       1'b0, 1'b0);
    push_bin(24'd10,       1'b1, 1'b0);
    push_bin(24'd10,       1'b0, 1'b1);
    push_bin(24'd0,        1'b0, 1'b0);
    push_bin(24'd1,        1'b1, 1'b0);
    push_bin(24'hFFFFFF,   1'b0, 1'b1);
    // tiny negative curvature, huge slope; flag on the last bin is dropped
    push_bin(24'd0,        1'b0, 1'b0);
    push_bin(24'h800000,   1'b1, 1'b0);
    push_bin(24'hFFFFFF,   1'b0, 1'b0);
    push_bin(24'd3,        1'b1, 1'b1);
  endtask

  task automatic test_bin_width_extremes;
    set_bin_width(32'hFFFF_FFFF);
    push_bin(24'd0,        1'b0, 1'b0);
    push_bin(24'h800000,   1'b1, 1'b0);
    push_bin(24'hFFFFFF,   1'b1, 1'b0);
    push_bin(24'd0,        1'b0, 1'b1);
    set_bin_width(32'h0);
    push_bin(24'd1,        1'b0, 1'b0);
    push_bin(24'd9,        1'b1, 1'b0);
    push_bin(24'd2,        1'b0, 1'b1);
  endtask

  task automatic test_random_frames;
    int phase, sent, len;
    logic [31:0] bw;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: bw = $urandom;
        1: bw = $urandom_range(0, 32'h000F_FFFF);
        2: bw = 32'hFFFF_FFFF;
        3: bw = 32'h0;
        default: bw = $urandom;
      endcase
      set_bin_width(bw);
      sent = 0;
      while (sent < 70) begin
        len = frame_len();
        send_random_frame(len);
        sent += len;
      end
    end
  endtask

  // closing stretch at full rate on both sides, but for the stalls while a fit runs
  task automatic test_steady_stream;
    int sent, len;
    set_bin_width(BW_RESET);
    gaps_on = 1'b0;
    sent = 0;
    while (sent < 60) begin
      len = frame_len();
      send_random_frame(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_frames();
    test_peak_shapes();
    test_bin_width_extremes();
    test_random_frames();
    test_steady_stream();
    drain();
    if (mismatches == 0 && peak_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* spectral_peak_parabolic_interp_unit.f */
hdl/sppi_pkg.sv
hdl/sppi_mdu.sv
hdl/sppi_core.sv
hdl/spectral_peak_parabolic_interp_unit.sv
tb/tb_spectral_peak_parabolic_interp_unit.sv
